### rtl/core/series_parallel_reliability_reducer_top_assert.svh
// Assertion macros for the series-parallel reliability reducer.
`ifndef SERIES_PARALLEL_RELIABILITY_REDUCER_TOP_ASSERT_SVH
`define SERIES_PARALLEL_RELIABILITY_REDUCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPRR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprr same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprr next-cycle check failed");

`endif

### rtl/core/sprr_pkg.sv
package sprr_pkg;

  // Default sizing.
  localparam int DEF_MAX_EDGES    = 256;
  localparam int DEF_NODE_ID_BITS = 8;

  // Fixed field widths.
  localparam int NODE_PORT_W = 8;
  localparam int REL_W       = 16;
  localparam int STATUS_W    = 2;

  typedef logic [REL_W-1:0]    rel_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes.
  localparam status_t ST_REDUCED     = 2'd0;
  localparam status_t ST_IRREDUCIBLE = 2'd1;
  localparam status_t ST_OVERFLOW    = 2'd2;

endpackage

### rtl/core/sprr_store.sv
module sprr_store #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);
  import sprr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Edge store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/series_parallel_reliability_reducer_top.sv
// Channel   Handshake          Ports
// input     start && !busy     in_start_node, in_end_node, in_edge_reliability, in_last_edge
// result    out_valid (1 cyc)  out_total_reliability, out_status
//
// Edges load one per cycle into the edge store while busy is low. After the last
// edge a sequencer walks edge pairs through the edge store, with a node-sharing
// scan over the edges for each series candidate and a multiply-and-write step per
// merge; busy is high throughout.
// Reset (synchronous, rst_n low) empties the store; there is no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module series_parallel_reliability_reducer_top #(
  parameter int MAX_EDGES    = sprr_pkg::DEF_MAX_EDGES,
  parameter int NODE_ID_BITS = sprr_pkg::DEF_NODE_ID_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [sprr_pkg::NODE_PORT_W-1:0] in_start_node,
  input  logic [sprr_pkg::NODE_PORT_W-1:0] in_end_node,
  input  sprr_pkg::rel_t                   in_edge_reliability,
  input  logic                             in_last_edge,
  output logic                             out_valid,
  output sprr_pkg::rel_t                   out_total_reliability,
  output sprr_pkg::status_t                out_status
);
  import sprr_pkg::*;

  localparam int NB = NODE_ID_BITS;
  localparam int IW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int DW = 2 * NB + REL_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_I_RD  = 4'd1;
  localparam logic [3:0] S_I_WT  = 4'd2;
  localparam logic [3:0] S_J_RD  = 4'd3;
  localparam logic [3:0] S_J_WT  = 4'd4;
  localparam logic [3:0] S_L_RD  = 4'd5;
  localparam logic [3:0] S_L_WT  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;
  localparam logic [3:0] S_WRJ   = 4'd9;
  localparam logic [3:0] S_NJ    = 4'd10;
  localparam logic [3:0] S_NI    = 4'd11;
  localparam logic [3:0] S_C_RD  = 4'd12;
  localparam logic [3:0] S_C_WT  = 4'd13;

  logic [3:0]        state_r;
  logic [CW-1:0]     count_r, n_r, i_r, j_r, l_r;
  logic              ovf_r, par_r, s_merged_r, p_merged_r;
  logic [NB-1:0]     ei_s_r, ei_e_r, ej_s_r, ej_e_r;
  rel_t              ei_v_r, ej_v_r, v0_r;
  logic [2*REL_W-1:0] prod_r;
  logic              out_valid_r;
  rel_t              out_total_r;
  status_t           out_status_r;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [DW-1:0]     wdata, rdata;
  logic [NB-1:0]     rd_s, rd_e;
  rel_t              rd_v;
  logic              accept;
  logic [REL_W:0]    par_sum;
  rel_t              par_val, ser_val;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign {rd_s, rd_e, rd_v} = rdata;

  // Merge arithmetic from the registered product.
  assign ser_val = prod_r[2*REL_W-1:REL_W];
  assign par_sum = {1'b0, ei_v_r} + {1'b0, ej_v_r} - {1'b0, prod_r[2*REL_W-1:REL_W]};
  assign par_val = par_sum[REL_W] ? {REL_W{1'b1}} : par_sum[REL_W-1:0];

  // Store address and write selection.
  always_comb begin
    we    = 1'b0;
    waddr = count_r[IW-1:0];
    wdata = {NB'(in_start_node), NB'(in_end_node), in_edge_reliability};
    raddr = l_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        we = accept && (count_r < CW'(MAX_EDGES));
      end
      S_APPLY: begin
        we    = 1'b1;
        waddr = i_r[IW-1:0];
        wdata = par_r ? {ei_s_r, ei_e_r, par_val} : {ei_s_r, ej_e_r, ser_val};
      end
      S_WRJ: begin
        we    = 1'b1;
        waddr = j_r[IW-1:0];
        wdata = {ej_s_r, ej_e_r, {REL_W{1'b0}}};
      end
      default: begin
      end
    endcase
    if (state_r == S_I_RD) begin
      raddr = i_r[IW-1:0];
    end else if (state_r == S_J_RD) begin
      raddr = j_r[IW-1:0];
    end
  end

  sprr_store #(
    .DEPTH  (MAX_EDGES),
    .DATA_W (DW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Payload registers of the working pair and the product.
  always_ff @(posedge clk) begin
    if (state_r == S_I_WT) begin
      ei_s_r <= rd_s;
      ei_e_r <= rd_e;
      ei_v_r <= rd_v;
    end
    if (state_r == S_J_WT) begin
      ej_s_r <= rd_s;
      ej_e_r <= rd_e;
      ej_v_r <= rd_v;
    end
    if (state_r == S_MUL) begin
      prod_r <= ei_v_r * ej_v_r;
    end
    if (state_r == S_APPLY) begin
      ei_v_r <= par_r ? par_val : ser_val;
      if (!par_r) begin
        ei_e_r <= ej_e_r;
      end
    end
    if (state_r == S_C_WT && l_r == '0) begin
      v0_r <= rd_v;
    end
  end

  // Sequencer: load, series pass, parallel pass, liveness check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (count_r < CW'(MAX_EDGES)) begin
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_edge) begin
              if (ovf_r || count_r == CW'(MAX_EDGES)) begin
                out_valid_r  <= 1'b1;
                out_total_r  <= '0;
                out_status_r <= ST_OVERFLOW;
                count_r      <= '0;
                ovf_r        <= 1'b0;
              end else begin
                n_r        <= count_r + 1'b1;
                i_r        <= '0;
                par_r      <= 1'b0;
                s_merged_r <= 1'b0;
                p_merged_r <= 1'b0;
                state_r    <= S_I_RD;
              end
            end
          end
        end
        S_I_RD: begin
          state_r <= S_I_WT;
        end
        S_I_WT: begin
          j_r     <= i_r;
          state_r <= (rd_v == '0) ? S_NI : S_NJ;
        end
        S_NJ: begin
          if (ei_v_r == '0 || j_r + 1'b1 >= n_r) begin
            state_r <= S_NI;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_J_RD;
          end
        end
        S_NI: begin
          if (i_r + 1'b1 >= n_r) begin
            i_r <= '0;
            l_r <= '0;
            if (!par_r) begin
              par_r   <= 1'b1;
              state_r <= S_I_RD;
            end else begin
              state_r <= S_C_RD;
            end
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_I_RD;
          end
        end
        S_J_RD: begin
          state_r <= S_J_WT;
        end
        S_J_WT: begin
          state_r <= S_NJ;
          if (rd_v != '0) begin
            if (!par_r) begin
              if (ei_e_r == rd_s && ei_s_r != rd_e) begin
                l_r     <= '0;
                state_r <= S_L_RD;
              end
            end else if ((ei_s_r == rd_s && ei_e_r == rd_e) ||
                         (ei_s_r == rd_e && ei_e_r == rd_s)) begin
              state_r <= S_MUL;
            end
          end
        end
        // Scan for another live edge touching the shared node.
        S_L_RD: begin
          state_r <= (l_r == n_r) ? S_MUL : S_L_WT;
        end
        S_L_WT: begin
          if (l_r != i_r && l_r != j_r && rd_v != '0 &&
              (rd_s == ei_e_r || rd_e == ei_e_r)) begin
            state_r <= S_NJ;
          end else begin
            l_r     <= l_r + 1'b1;
            state_r <= S_L_RD;
          end
        end
        S_MUL: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (par_r) begin
            p_merged_r <= 1'b1;
          end else begin
            s_merged_r <= 1'b1;
          end
          state_r <= S_WRJ;
        end
        S_WRJ: begin
          state_r <= S_NJ;
        end
        // Check whether only the first edge is still live.
        S_C_RD: begin
          if (l_r == n_r) begin
            out_valid_r  <= 1'b1;
            out_total_r  <= v0_r;
            out_status_r <= ST_REDUCED;
            count_r      <= '0;
            ovf_r        <= 1'b0;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_C_WT;
          end
        end
        S_C_WT: begin
          if (l_r != '0 && rd_v != '0) begin
            if (!s_merged_r && !p_merged_r) begin
              out_valid_r  <= 1'b1;
              out_total_r  <= '0;
              out_status_r <= ST_IRREDUCIBLE;
              count_r      <= '0;
              ovf_r        <= 1'b0;
              state_r      <= S_IDLE;
            end else begin
              i_r        <= '0;
              par_r      <= 1'b0;
              s_merged_r <= 1'b0;
              p_merged_r <= 1'b0;
              state_r    <= S_I_RD;
            end
          end else begin
            l_r     <= l_r + 1'b1;
            state_r <= S_C_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_total_reliability = out_total_r;
  assign out_status            = out_status_r;

`include "series_parallel_reliability_reducer_top_assert.svh"

  // A result beat always lands with the block idle, and never twice in a row.
  `SPRR_ASSERT_NOW(a_result_idle, out_valid_r, state_r == S_IDLE)
  `SPRR_ASSERT_NEXT(a_single_beat, out_valid_r, !out_valid_r)
  // A result empties the store for the next network.
  `SPRR_ASSERT_NOW(a_result_clears, out_valid_r, count_r == '0 && !ovf_r)
  // The edge count never runs past the store depth.
  `SPRR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_EDGES))

endmodule

### verif/series_parallel_reliability_reducer_top_tb.sv
`timescale 1ns / 1ps

module series_parallel_reliability_reducer_top_tb;
  import sprr_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_EDGES;
  localparam int NODE_MASK = (1 << DEF_NODE_ID_BITS) - 1;

  // One edge beat plus how the sender presents it.
  typedef struct {
    logic [NODE_PORT_W-1:0] s_node;
    logic [NODE_PORT_W-1:0] e_node;
    rel_t                   rel;
    logic                   last;
    int                     gap;
    bit                     drain;
    bit                     has_want;
    rel_t                   want_total;
    status_t                want_status;
  } edge_beat_t;

  typedef struct packed {
    logic [7:0] s_node;
    logic [7:0] e_node;
    rel_t       rel;
    logic       last;
    logic       has_want;
    rel_t       want_total;
    status_t    want_status;
  } dir_row_t;

  typedef struct {
    rel_t    total;
    status_t status;
  } net_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [NODE_PORT_W-1:0] in_start_node = '0;
  logic [NODE_PORT_W-1:0] in_end_node = '0;
  rel_t                   in_edge_reliability = '0;
  logic                   in_last_edge = 1'b0;
  logic                   out_valid;
  rel_t                   out_total_reliability;
  status_t                out_status;

  edge_beat_t  beat_q[$];
  net_result_t result_q[$];
  int          errors = 0;
  bit          sender_go = 1'b0;
  bit          all_sent = 1'b0;

  // Shadow copy of the edge store.
  logic [7:0] sh_start[STORE_DEPTH];
  logic [7:0] sh_end[STORE_DEPTH];
  rel_t       sh_value[STORE_DEPTH];
  int         sh_count = 0;
  bit         sh_overflow = 1'b0;

  always #2 clk = ~clk;

  series_parallel_reliability_reducer_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_node(in_start_node), .in_end_node(in_end_node),
    .in_edge_reliability(in_edge_reliability), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_total_reliability(out_total_reliability),
    .out_status(out_status)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // True when a live edge other than a and b touches node.
  function automatic bit node_touched(int n, int a, int b, logic [7:0] node);
    for (int l = 0; l < n; l++) begin
      if (l != a && l != b && sh_value[l] != 0 &&
          (sh_start[l] == node || sh_end[l] == node)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Reduce the shadow network and give its reliability and status.
  function automatic net_result_t reduce_network();
    net_result_t r;
    int          n;
    bit          merged_s;
    bit          merged_p;
    bit          rest_dead;
    int unsigned prod;
    int unsigned sum;
    n = sh_count;
    r.total = '0;
    r.status = ST_REDUCED;
    if (sh_overflow) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    forever begin
      merged_s = 1'b0;
      merged_p = 1'b0;
      // Series pass: merge through a node that no other live edge touches.
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (sh_value[i] == 0 || sh_value[j] == 0) continue;
          if (sh_end[i] != sh_start[j] || sh_start[i] == sh_end[j]) continue;
          if (node_touched(n, i, j, sh_end[i])) continue;
          prod = sh_value[i] * sh_value[j];
          sh_value[i] = prod[31:16];
          sh_end[i] = sh_end[j];
          sh_value[j] = '0;
          merged_s = 1'b1;
        end
      end
      // Parallel pass: same endpoints in either orientation.
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (sh_value[i] == 0 || sh_value[j] == 0) continue;
          if (!((sh_start[i] == sh_start[j] && sh_end[i] == sh_end[j]) ||
                (sh_start[i] == sh_end[j] && sh_end[i] == sh_start[j]))) continue;
          prod = sh_value[i] * sh_value[j];
          sum = sh_value[i] + sh_value[j] - (prod >> 16);
          sh_value[i] = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
          sh_value[j] = '0;
          merged_p = 1'b1;
        end
      end
      rest_dead = 1'b1;
      for (int t = 1; t < n; t++) if (sh_value[t] != 0) rest_dead = 1'b0;
      if (rest_dead) begin
        r.total = sh_value[0];
        return r;
      end
      if (!merged_s && !merged_p) begin
        r.status = ST_IRREDUCIBLE;
        return r;
      end
    end
  endfunction

  // Store one accepted beat in the shadow and queue the network result on the last edge.
  task automatic absorb_beat(input edge_beat_t b);
    net_result_t r;
    if (sh_count < STORE_DEPTH) begin
      sh_start[sh_count] = 8'(b.s_node & NODE_MASK);
      sh_end[sh_count] = 8'(b.e_node & NODE_MASK);
      sh_value[sh_count] = b.rel;
      sh_count++;
    end else begin
      sh_overflow = 1'b1;
    end
    if (b.last) begin
      r = reduce_network();
      if (b.has_want) begin
        r.total = b.want_total;
        r.status = b.want_status;
      end
      result_q.push_back(r);
      sh_count = 0;
      sh_overflow = 1'b0;
    end
  endtask

  // Sender: presents queued beats, honoring gaps and drain requests.
  edge_beat_t cur_beat;
  edge_beat_t next_beat;
  bit         have_next = 1'b0;
  int         gap_left = 0;

  always @(posedge clk) begin
    logic start_nxt;
    start_nxt = start;
    if (start && !busy) begin
      absorb_beat(cur_beat);
      start_nxt = 1'b0;
    end
    if (sender_go && !start_nxt) begin
      if (!have_next && beat_q.size() != 0) begin
        next_beat = beat_q.pop_front();
        gap_left = next_beat.gap;
        have_next = 1'b1;
      end
      if (have_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!next_beat.drain || result_q.size() == 0) begin
          cur_beat = next_beat;
          have_next = 1'b0;
          start_nxt = 1'b1;
          in_start_node <= next_beat.s_node;
          in_end_node <= next_beat.e_node;
          in_edge_reliability <= next_beat.rel;
          in_last_edge <= next_beat.last;
        end
      end else begin
        all_sent <= 1'b1;
      end
    end
    start <= start_nxt;
  end

  // Result checker: every strobed beat is matched with the oldest network result.
  always @(posedge clk) begin
    net_result_t w;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", out_total_reliability, 0);
      end else begin
        w = result_q.pop_front();
        if (out_total_reliability !== w.total)
          report_mismatch("total_reliability", out_total_reliability, w.total);
        if (out_status !== w.status)
          report_mismatch("status", out_status, w.status);
      end
    end
  end

  int phase_idle = 0;

  function automatic int pick_gap();
    int g;
    g = 0;
    while (g < 20 && $urandom_range(99) < phase_idle) g++;
    return g;
  endfunction

  task automatic add_beat(input logic [7:0] s, input logic [7:0] e, input rel_t rel,
                          input logic last, input bit drain = 1'b0);
    edge_beat_t b;
    b.s_node = s;
    b.e_node = e;
    b.rel = rel;
    b.last = last;
    b.gap = pick_gap();
    b.drain = drain;
    b.has_want = 1'b0;
    b.want_total = '0;
    b.want_status = ST_REDUCED;
    beat_q.push_back(b);
  endtask

  function automatic rel_t pick_rel();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return '0;
      default: return rel_t'($urandom_range(16'hFFFF, 1));
    endcase
  endfunction

  // Build a series-parallel network by repeated splitting, then send it.
  task automatic add_sp_network(input int n_edges, input bit drain);
    logic [7:0] es[$];
    logic [7:0] ee[$];
    logic [7:0] next_node;
    logic [7:0] tmp;
    int         k;
    next_node = 8'($urandom_range(255));
    es.push_back(next_node);
    ee.push_back(next_node + 8'd1);
    next_node = next_node + 8'd2;
    while (es.size() < n_edges) begin
      k = $urandom_range(es.size() - 1);
      if ($urandom_range(1)) begin
        es.insert(k + 1, next_node);
        ee.insert(k + 1, ee[k]);
        ee[k] = next_node;
        next_node++;
      end else if ($urandom_range(1)) begin
        es.push_back(es[k]);
        ee.push_back(ee[k]);
      end else begin
        es.push_back(ee[k]);
        ee.push_back(es[k]);
      end
    end
    // Occasionally flip an edge to vary its direction.
    for (int i = 0; i < es.size(); i++) begin
      if ($urandom_range(7) == 0) begin
        tmp = es[i];
        es[i] = ee[i];
        ee[i] = tmp;
      end
    end
    for (int i = 0; i < es.size(); i++)
      add_beat(es[i], ee[i], pick_rel(), i == es.size() - 1, drain && i == 0);
  endtask

  // Random edges over a few nodes, or over the whole id range.
  task automatic add_noise_network(input int n_edges);
    logic [7:0] base;
    bit         wide;
    base = 8'($urandom_range(255));
    wide = $urandom_range(3) == 0;
    for (int i = 0; i < n_edges; i++)
      add_beat(wide ? 8'($urandom_range(255)) : base + 8'($urandom_range(3)),
               wide ? 8'($urandom_range(255)) : base + 8'($urandom_range(3)),
               pick_rel(), i == n_edges - 1);
  endtask

  dir_row_t dir_tab[] = '{
    '{8'd0,   8'd255, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, ST_REDUCED},
    '{8'd255, 8'd0,   16'h0000, 1'b1, 1'b1, 16'h0000, ST_REDUCED},
    '{8'd0,   8'd1,   16'hFFFF, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd1,   8'd2,   16'hFFFF, 1'b1, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd3,   8'd4,   16'h8000, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd4,   8'd3,   16'h8000, 1'b1, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd7,   8'd9,   16'hFFFF, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd7,   8'd9,   16'hFFFF, 1'b1, 1'b1, 16'hFFFF, ST_REDUCED},
    '{8'd0,   8'd1,   16'h0001, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd1,   8'd2,   16'h0001, 1'b1, 1'b1, 16'h0000, ST_REDUCED},
    '{8'd0,   8'd1,   16'h1234, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd2,   8'd3,   16'h5678, 1'b1, 1'b1, 16'h0000, ST_IRREDUCIBLE},
    '{8'd5,   8'd5,   16'h4000, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd5,   8'd5,   16'h4000, 1'b1, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd0,   8'd1,   16'h9000, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd1,   8'd2,   16'h9000, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd1,   8'd3,   16'h9000, 1'b1, 1'b1, 16'h0000, ST_IRREDUCIBLE},
    '{8'd0,   8'd1,   16'h0000, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd0,   8'd1,   16'h9000, 1'b1, 1'b1, 16'h0000, ST_IRREDUCIBLE},
    '{8'd170, 8'd85,  16'hAAAA, 1'b0, 1'b0, 16'h0000, ST_REDUCED},
    '{8'd85,  8'd170, 16'h5555, 1'b1, 1'b0, 16'h0000, ST_REDUCED}
  };

  // Stimulus and end of run.
  initial begin
    edge_beat_t b;
    int         beats;
    for (int i = 0; i < dir_tab.size(); i++) begin
      add_beat(dir_tab[i].s_node, dir_tab[i].e_node, dir_tab[i].rel, dir_tab[i].last);
      b = beat_q.pop_back();
      b.has_want = dir_tab[i].has_want;
      b.want_total = dir_tab[i].want_total;
      b.want_status = dir_tab[i].want_status;
      beat_q.push_back(b);
    end
    // Store exactly full: only edge 0 live, so one cheap round.
    for (int i = 0; i < STORE_DEPTH; i++)
      add_beat(8'd10, 8'd11, i == 0 ? 16'h7777 : 16'h0000, i == STORE_DEPTH - 1);
    // One edge too many, with the last edge itself dropped.
    for (int i = 0; i <= STORE_DEPTH; i++)
      add_beat(8'($urandom_range(255)), 8'($urandom_range(255)), 16'h0000,
               i == STORE_DEPTH, i == 0);
    b = beat_q.pop_back();
    b.has_want = 1'b1;
    b.want_total = '0;
    b.want_status = ST_OVERFLOW;
    beat_q.push_back(b);

    // Random networks over the idling phases.
    beats = 0;
    for (int ph = 0; ph < 4; ph++) begin
      phase_idle = (ph == 0) ? 0 : (ph == 3) ? 31 : 46;
      while (beats < (ph + 1) * 370) begin
        if ($urandom_range(3) != 0) add_sp_network($urandom_range(9, 1), $urandom_range(15) == 0);
        else add_noise_network($urandom_range(6, 1));
        beats = beat_q.size() - dir_tab.size() - 2 * STORE_DEPTH - 1;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    sender_go <= 1'b1;
    wait (all_sent && result_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule
